@@ src/rbsd_pkg.sv @@
`default_nettype none
package rbsd_pkg;
  localparam int FIELD_W = 48;
  localparam int ROT_FRAC = 30;
  localparam int INERTIA_FRAC = 40;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_XX = 3'd0,
    REG_XY = 3'd1,
    REG_XZ = 3'd2,
    REG_YY = 3'd3,
    REG_YZ = 3'd4,
    REG_ZZ = 3'd5
  } reg_idx_t;

  typedef logic signed [FIELD_W-1:0] fld_t;

  typedef struct packed {
    fld_t xx;
    fld_t xy;
    fld_t xz;
    fld_t yy;
    fld_t yz;
    fld_t zz;
  } inertia_t;

  // Round-half-up arithmetic shift of a 128-bit signed value, then 64-bit saturation.
  function automatic logic signed [63:0] shr_sat64(input logic signed [127:0] v,
                                                   input int s);
    logic signed [127:0] t;
    begin
      t = (v + (128'sd1 <<< (s - 1))) >>> s;
      if (t > 128'sd9223372036854775807) shr_sat64 = 64'sh7FFFFFFFFFFFFFFF;
      else if (t < -128'sd9223372036854775808) shr_sat64 = 64'sh8000000000000000;
      else shr_sat64 = t[63:0];
    end
  endfunction
endpackage
`default_nettype wire

@@ src/rigid_body_state_derivative.sv @@
`default_nettype none
// Rigid-body state derivative pipeline. One transaction is accepted per clock
// (busy is always low) and its result appears on the out_ ports, flagged by
// out_valid for exactly one cycle, after 2 scaling/norm stages, 31 divider
// stages (one quotient bit each), 9 stages for the three matrix-vector
// products (a pipelined multiply and a sum-and-round stage each) and 3 for
// the quaternion product (pipelined multiply) and saturation.
// The receiver cannot stall. The inverse inertia registers must be written
// only while no transaction is in flight.
module rigid_body_state_derivative
  import rbsd_pkg::*;
#(
  parameter int DATA_FRAC_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic signed [47:0]   in_quat_w,
  input  wire logic signed [47:0]   in_quat_x,
  input  wire logic signed [47:0]   in_quat_y,
  input  wire logic signed [47:0]   in_quat_z,
  input  wire logic signed [47:0]   in_vel_x,
  input  wire logic signed [47:0]   in_vel_y,
  input  wire logic signed [47:0]   in_vel_z,
  input  wire logic signed [47:0]   in_mom_x,
  input  wire logic signed [47:0]   in_mom_y,
  input  wire logic signed [47:0]   in_mom_z,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [47:0]          cfg_data,
  output logic                      out_valid,
  output logic signed [47:0]        out_pos_rate_x,
  output logic signed [47:0]        out_pos_rate_y,
  output logic signed [47:0]        out_pos_rate_z,
  output logic signed [47:0]        out_quat_rate_w,
  output logic signed [47:0]        out_quat_rate_x,
  output logic signed [47:0]        out_quat_rate_y,
  output logic signed [47:0]        out_quat_rate_z,
  output logic                      out_range_error
);
  localparam int ROT_LAT = 2 + ROT_FRAC + 1;
  localparam int OM_LAT = 9;
  // omega lands in the delay-line slot with this index
  localparam int OM_IDX = ROT_LAT + OM_LAT - 1;
  localparam int LAT = ROT_LAT + OM_LAT + 3;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // Config registers
  inertia_t inertia_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inertia_r.xx <= 48'sd1 <<< INERTIA_FRAC;
      inertia_r.yy <= 48'sd1 <<< INERTIA_FRAC;
      inertia_r.zz <= 48'sd1 <<< INERTIA_FRAC;
      inertia_r.xy <= '0;
      inertia_r.xz <= '0;
      inertia_r.yz <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_XX: inertia_r.xx <= cfg_data;
        REG_XY: inertia_r.xy <= cfg_data;
        REG_XZ: inertia_r.xz <= cfg_data;
        REG_YY: inertia_r.yy <= cfg_data;
        REG_YZ: inertia_r.yz <= cfg_data;
        REG_ZZ: inertia_r.zz <= cfg_data;
        default: ;
      endcase
    end
  end

  // Delay lines for valid, velocity, quaternion and momentum
  logic               vld_r [LAT];
  logic signed [47:0] vel_r [LAT-1][3];
  logic signed [47:0] qd_r  [OM_IDX+1][4];
  logic signed [47:0] md_r  [ROT_LAT][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= start;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    vel_r[0][0] <= in_vel_x; vel_r[0][1] <= in_vel_y; vel_r[0][2] <= in_vel_z;
    qd_r[0][0] <= in_quat_w; qd_r[0][1] <= in_quat_x;
    qd_r[0][2] <= in_quat_y; qd_r[0][3] <= in_quat_z;
    md_r[0][0] <= in_mom_x; md_r[0][1] <= in_mom_y; md_r[0][2] <= in_mom_z;
    for (int i = 1; i < LAT - 1; i++) vel_r[i] <= vel_r[i-1];
    for (int i = 1; i <= OM_IDX; i++) qd_r[i] <= qd_r[i-1];
    for (int i = 1; i < ROT_LAT; i++) md_r[i] <= md_r[i-1];
  end

  logic signed [31:0] rot [9];
  logic zero_q;
  rbsd_rot u_rot (
    .clk(clk), .q_w(in_quat_w), .q_x(in_quat_x), .q_y(in_quat_y), .q_z(in_quat_z),
    .rot(rot), .zero_q(zero_q)
  );

  // Align momentum with the rotation matrix from u_rot.
  logic signed [47:0] mom_al [3];
  always_comb mom_al = md_r[ROT_LAT-1];

  logic zero_d_r [OM_LAT];
  always_ff @(posedge clk) begin
    zero_d_r[0] <= zero_q;
    for (int i = 1; i < OM_LAT; i++) zero_d_r[i] <= zero_d_r[i-1];
  end

  logic signed [63:0] omega [3];
  rbsd_omega u_om (
    .clk(clk), .rot(rot), .mom(mom_al), .inertia(inertia_r), .omega(omega)
  );

  // Quaternion product (0,omega)*q with raw q; the multipliers are pipelined.
  logic signed [63:0]  pm_a [12], pm_b [12];
  logic signed [127:0] pp [12];
  logic zero_e_r [2];

  always_comb begin
    logic signed [63:0] w, x, y, z;
    w = 64'(qd_r[OM_IDX][0]); x = 64'(qd_r[OM_IDX][1]);
    y = 64'(qd_r[OM_IDX][2]); z = 64'(qd_r[OM_IDX][3]);
    pm_a[0] = omega[0]; pm_b[0] = x;
    pm_a[1] = omega[1]; pm_b[1] = y;
    pm_a[2] = omega[2]; pm_b[2] = z;
    pm_a[3] = omega[0]; pm_b[3] = w;
    pm_a[4] = omega[1]; pm_b[4] = z;
    pm_a[5] = omega[2]; pm_b[5] = y;
    pm_a[6] = omega[1]; pm_b[6] = w;
    pm_a[7] = omega[2]; pm_b[7] = x;
    pm_a[8] = omega[0]; pm_b[8] = z;
    pm_a[9] = omega[2]; pm_b[9] = w;
    pm_a[10] = omega[0]; pm_b[10] = y;
    pm_a[11] = omega[1]; pm_b[11] = x;
  end

  for (genvar g = 0; g < 12; g++) begin : g_qmul
    rbsd_mul u_qm (.clk(clk), .a(pm_a[g]), .b(pm_b[g]), .p(pp[g]));
  end

  always_ff @(posedge clk) begin
    zero_e_r[0] <= zero_d_r[OM_LAT-1];
    zero_e_r[1] <= zero_e_r[0];
  end

  function automatic logic [48:0] sat48(input logic signed [127:0] v);
    logic signed [127:0] t;
    begin
      t = (v + (128'sd1 <<< DATA_FRAC_BITS)) >>> (DATA_FRAC_BITS + 1);
      if (t > 128'sd140737488355327) sat48 = {1'b1, 48'h7FFFFFFFFFFF};
      else if (t < -128'sd140737488355328) sat48 = {1'b1, 48'h800000000000};
      else sat48 = {1'b0, t[47:0]};
    end
  endfunction

  logic [48:0] rw, rx, ry, rz;
  always_comb begin
    rw = sat48(-(pp[0] + pp[1] + pp[2]));
    rx = sat48(pp[3] + pp[4] - pp[5]);
    ry = sat48(pp[6] + pp[7] - pp[8]);
    rz = sat48(pp[9] + pp[10] - pp[11]);
  end

  always_ff @(posedge clk) begin
    out_pos_rate_x <= vel_r[LAT-2][0];
    out_pos_rate_y <= vel_r[LAT-2][1];
    out_pos_rate_z <= vel_r[LAT-2][2];
    out_quat_rate_w <= zero_e_r[1] ? '0 : $signed(rw[47:0]);
    out_quat_rate_x <= zero_e_r[1] ? '0 : $signed(rx[47:0]);
    out_quat_rate_y <= zero_e_r[1] ? '0 : $signed(ry[47:0]);
    out_quat_rate_z <= zero_e_r[1] ? '0 : $signed(rz[47:0]);
    out_range_error <= zero_e_r[1] | rw[48] | rx[48] | ry[48] | rz[48];
  end

  always_comb out_valid = vld_r[LAT-1];

  a_busy: assert property (@(posedge clk) busy == 1'b0) else $error("busy high");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld_r[LAT-2])) else $error("valid chain broken");
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_range_error)) else $error("flag unknown");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready) else $error("cfg not ready");
endmodule
`default_nettype wire

@@ src/rbsd_rot.sv @@
`default_nettype none
// Quaternion block scaling and rotation matrix: normalize -> products -> divide.
module rbsd_rot
  import rbsd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [47:0] q_w,
  input  wire logic signed [47:0] q_x,
  input  wire logic signed [47:0] q_y,
  input  wire logic signed [47:0] q_z,
  output logic signed [31:0]      rot [9],
  output logic                    zero_q
);
  // Stage 1: scale the quaternion so its largest magnitude lies in [2^29,2^30).
  logic [47:0] mag [4];
  logic signed [47:0] qs [4];
  logic [47:0] mx;
  logic [5:0] lead;
  logic signed [31:0] s_r [4];
  logic zero_r;

  always_comb begin
    qs[0] = q_w; qs[1] = q_x; qs[2] = q_y; qs[3] = q_z;
    mx = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = qs[i][47] ? 48'(-qs[i]) : 48'(qs[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    lead = '0;
    for (int i = 0; i < 48; i++) begin
      if (mx[i]) lead = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    zero_r <= (mx == '0);
    for (int i = 0; i < 4; i++) begin
      logic [47:0] m;
      m = (lead >= 6'd29) ? (mag[i] >> (lead - 6'd29)) : (mag[i] << (6'd29 - lead));
      s_r[i] <= qs[i][47] ? -$signed({1'b0, m[30:0]}) : $signed({1'b0, m[30:0]});
    end
  end

  // Stage 2: numerators and norm.
  logic signed [63:0] num_r [9];
  logic signed [63:0] n_r;
  logic zero2_r;
  always_ff @(posedge clk) begin
    logic signed [63:0] w, x, y, z, ww, xx, yy, zz;
    w = 64'(s_r[0]); x = 64'(s_r[1]); y = 64'(s_r[2]); z = 64'(s_r[3]);
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    n_r <= ww + xx + yy + zz;
    num_r[0] <= ww + xx - yy - zz;
    num_r[1] <= 64'sd2 * (x * y - w * z);
    num_r[2] <= 64'sd2 * (x * z + w * y);
    num_r[3] <= 64'sd2 * (x * y + w * z);
    num_r[4] <= ww - xx + yy - zz;
    num_r[5] <= 64'sd2 * (y * z - w * x);
    num_r[6] <= 64'sd2 * (x * z - w * y);
    num_r[7] <= 64'sd2 * (y * z + w * x);
    num_r[8] <= ww - xx - yy + zz;
    zero2_r <= zero_r;
  end

  // Stages 3..33: restoring divide, one quotient bit per stage.
  localparam int DSTG = ROT_FRAC + 1;
  logic [63:0] rem_r [DSTG+1][9];
  logic [31:0] quo_r [DSTG+1][9];
  logic        neg_r [DSTG+1][9];
  logic [63:0] den_r [DSTG+1];
  logic        zp_r  [DSTG+1];

  always_comb begin
    den_r[0] = n_r;
    zp_r[0] = zero2_r;
    for (int e = 0; e < 9; e++) begin
      neg_r[0][e] = num_r[e][63];
      rem_r[0][e] = num_r[e][63] ? 64'(-num_r[e]) : 64'(num_r[e]);
      quo_r[0][e] = '0;
    end
  end

  for (genvar g = 0; g < DSTG; g++) begin : g_div
    always_ff @(posedge clk) begin
      den_r[g+1] <= den_r[g];
      zp_r[g+1] <= zp_r[g];
      for (int e = 0; e < 9; e++) begin
        logic [63:0] r;
        r = (g == 0) ? rem_r[g][e] : {rem_r[g][e][62:0], 1'b0};
        neg_r[g+1][e] <= neg_r[g][e];
        if (r >= den_r[g]) begin
          rem_r[g+1][e] <= (g == 0 && (r - den_r[g]) >= den_r[g]) ? '0 : r - den_r[g];
          quo_r[g+1][e] <= {quo_r[g][e][30:0], 1'b1};
        end else begin
          rem_r[g+1][e] <= r;
          quo_r[g+1][e] <= {quo_r[g][e][30:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int e = 0; e < 9; e++) begin
      rot[e] = neg_r[DSTG][e] ? -$signed(quo_r[DSTG][e]) : $signed(quo_r[DSTG][e]);
    end
    zero_q = zp_r[DSTG];
  end
endmodule
`default_nettype wire

@@ src/rbsd_omega.sv @@
`default_nettype none
// Pipelined signed 64x64 multiply: four registered 33x33 partial products, then their sum.
module rbsd_mul
  import rbsd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  output logic signed [127:0]     p
);
  logic signed [32:0] al, ah, bl, bh;
  logic signed [65:0] ll_r, lh_r, hl_r, hh_r;

  always_comb begin
    al = $signed({1'b0, a[31:0]});
    ah = $signed({a[63], a[63:32]});
    bl = $signed({1'b0, b[31:0]});
    bh = $signed({b[63], b[63:32]});
  end

  always_ff @(posedge clk) begin
    ll_r <= al * bl;
    lh_r <= al * bh;
    hl_r <= ah * bl;
    hh_r <= ah * bh;
    p <= (128'(hh_r) <<< 64) + (128'(hl_r) <<< 32) + (128'(lh_r) <<< 32) + 128'(ll_r);
  end
endmodule

// omega = R*(Ib*(R^T*L)); each product is a pipelined multiply, then a sum-and-round stage.
module rbsd_omega
  import rbsd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [31:0] rot [9],
  input  wire logic signed [47:0] mom [3],
  input  wire inertia_t           inertia,
  output logic signed [63:0]      omega [3]
);
  // R waits here until b = Ib*a is ready.
  localparam int ROT_DLY = 6;

  logic signed [63:0]  ma_a [9], ma_b [9], mb_a [9], mb_b [9], mc_a [9], mc_b [9];
  logic signed [127:0] pa [9], pb [9], pc [9];
  logic signed [31:0]  rot_d_r [ROT_DLY][9];
  logic signed [63:0]  a_r [3], b_r [3];
  logic signed [47:0]  ib [9];

  always_comb begin
    ib[0] = inertia.xx; ib[1] = inertia.xy; ib[2] = inertia.xz;
    ib[3] = inertia.xy; ib[4] = inertia.yy; ib[5] = inertia.yz;
    ib[6] = inertia.xz; ib[7] = inertia.yz; ib[8] = inertia.zz;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ma_a[i*3+j] = 64'(rot[j*3+i]);
        ma_b[i*3+j] = 64'(mom[j]);
      end
    end
    for (int i = 0; i < 9; i++) begin
      mb_a[i] = 64'(ib[i]);
      mb_b[i] = a_r[i%3];
      mc_a[i] = 64'(rot_d_r[ROT_DLY-1][i]);
      mc_b[i] = b_r[i%3];
    end
  end

  for (genvar g = 0; g < 9; g++) begin : g_mul
    rbsd_mul u_ma (.clk(clk), .a(ma_a[g]), .b(ma_b[g]), .p(pa[g]));
    rbsd_mul u_mb (.clk(clk), .a(mb_a[g]), .b(mb_b[g]), .p(pb[g]));
    rbsd_mul u_mc (.clk(clk), .a(mc_a[g]), .b(mc_b[g]), .p(pc[g]));
  end

  always_ff @(posedge clk) begin
    rot_d_r[0] <= rot;
    for (int i = 1; i < ROT_DLY; i++) rot_d_r[i] <= rot_d_r[i-1];
    for (int i = 0; i < 3; i++) begin
      a_r[i] <= shr_sat64(pa[i*3] + pa[i*3+1] + pa[i*3+2], ROT_FRAC);
      b_r[i] <= shr_sat64(pb[i*3] + pb[i*3+1] + pb[i*3+2], INERTIA_FRAC);
      omega[i] <= shr_sat64(pc[i*3] + pc[i*3+1] + pc[i*3+2], ROT_FRAC);
    end
  end
endmodule
`default_nettype wire
